// ----- design/assert_macros.svh -----
// Assertion macros shared by the datapath and controller files.
// Each macro clocks on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/zzdr_pkg.sv -----
package zzdr_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int DIAG_W      = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register word indexes, taken from paddr[2].
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // write the arriving word into the store
        logic count_inc;    // advance the load count
        logic count_clear;  // return the load count to zero
        logic walk_init;    // place the walker on the first cell
        logic walk_step;    // read the current cell and move the walker on
    } zzdr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // the arriving word completes the matrix
        logic walk_last;  // the walker sits on the final cell
    } zzdr_status_t;

    // A dimension register of zero acts as one, above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            res = DIM_W'(MAX_DIM);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- design/zigzag_diagonal_reorder.sv -----
// Zigzag diagonal reorder. Matrix elements arrive in row-major order, one
// word per accepted start (start high while busy is low). The matrix size is
// taken from the row_count register (byte address 0) and the col_count
// register (byte address 4); a value of zero acts as one and a value above
// eight acts as eight. Busy stays low while loading, so words may be offered
// on every cycle. The word that completes the matrix (the load count reaching
// or passing rows * cols under the current registers) starts a run: busy rises
// at the next cycle and stays high while the walker reads the single store
// port one cell per cycle. Results follow in the cycle after each read, one
// word per cycle on result_valid, in zigzag diagonal order with the cell's
// row and column alongside, and last_of_run marks the final word. The first
// result is on the ports in the cycle after the run begins. The receiver
// cannot stall: each result is present for one cycle only and must be taken
// then. The size registers should only be written while the block is idle.
module zigzag_diagonal_reorder
    import zzdr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] element,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic                     last_of_run
);

    // Effective matrix dimensions, already clamped into range.
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;

    // Controller to datapath commands and the status that comes back.
    zzdr_cmd_t    cmd;
    zzdr_status_t status;

    // Configuration registers behind the APB-style port.
    zzdr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows),
        .cols    (cols)
    );

    // The controller decides between loading and running the traversal.
    zzdr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the store, the load count, the diagonal walker and
    // the registered result word.
    zzdr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rows         (rows),
        .cols         (cols),
        .element      (element),
        .status       (status),
        .result_valid (result_valid),
        .out_value    (out_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run)
    );

endmodule

// ----- design/zzdr_regs.sv -----
module zzdr_regs
    import zzdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [DIM_W-1:0]   rows,
    output logic [DIM_W-1:0]   cols
);

    logic [DIM_W-1:0] row_count_reg;
    logic [DIM_W-1:0] col_count_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= DIM_W'(MAX_DIM);
            col_count_reg <= DIM_W'(MAX_DIM);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROW_COUNT: row_count_reg <= pwdata[DIM_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[DIM_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = PDATA_W'(row_count_reg);
            REG_COL_COUNT: prdata = PDATA_W'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    assign rows = eff_dim(row_count_reg);
    assign cols = eff_dim(col_count_reg);

endmodule

// ----- design/zzdr_datapath.sv -----
`include "assert_macros.svh"

module zzdr_datapath
    import zzdr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  zzdr_cmd_t                cmd,
    input  logic [DIM_W-1:0]         rows,
    input  logic [DIM_W-1:0]         cols,
    input  logic signed [DATA_W-1:0] element,
    output zzdr_status_t             status,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic                     last_of_run
);

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    logic [ADDR_W-1:0] count_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  row_next;
    logic [IDX_W-1:0]  col_reg;
    logic [IDX_W-1:0]  col_next;
    logic [DIAG_W-1:0] diag_reg;
    logic [DIAG_W-1:0] diag_next;

    logic [DATA_W-1:0] rd_data_reg;
    logic              valid_reg;
    logic              last_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;

    logic [2*DIM_W-1:0] total_prod;
    logic [CNT_W-1:0]   total;
    logic [DIM_W-1:0]   rows_m1;
    logic [DIM_W-1:0]   cols_m1;
    logic [DIAG_W:0]    last_diag;
    logic [DIAG_W-1:0]  s1;
    logic [DIAG_W-1:0]  r4;
    logic [DIAG_W-1:0]  c4;
    logic               end_of_diag;
    logic               walk_last;
    logic [CNT_W-1:0]   rd_prod;
    logic [ADDR_W-1:0]  rd_addr;

    assign total_prod = {{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols};
    assign total      = total_prod[CNT_W-1:0];
    assign rows_m1    = rows - DIM_W'(1);
    assign cols_m1    = cols - DIM_W'(1);
    assign last_diag  = (DIAG_W+1)'(rows) + (DIAG_W+1)'(cols) - (DIAG_W+1)'(2);

    assign status.full      = (CNT_W'(count_reg) + CNT_W'(1)) >= total;
    assign status.walk_last = walk_last;

    // Even diagonals run up-right, odd ones down-left.
    always_comb
    begin
        if (!diag_reg[0])
        begin
            end_of_diag = (row_reg == '0) || (DIM_W'(col_reg) == cols_m1);
        end
        else
        begin
            end_of_diag = (col_reg == '0) || (DIM_W'(row_reg) == rows_m1);
        end
        walk_last = end_of_diag && ({1'b0, diag_reg} == last_diag);

        s1 = diag_reg + DIAG_W'(1);
        if (!s1[0])
        begin
            r4 = (s1 < rows_m1) ? s1 : rows_m1;
            c4 = s1 - r4;
        end
        else
        begin
            c4 = (s1 < cols_m1) ? s1 : cols_m1;
            r4 = s1 - c4;
        end

        if (end_of_diag)
        begin
            diag_next = s1;
            row_next  = r4[IDX_W-1:0];
            col_next  = c4[IDX_W-1:0];
        end
        else if (!diag_reg[0])
        begin
            diag_next = diag_reg;
            row_next  = row_reg - IDX_W'(1);
            col_next  = col_reg + IDX_W'(1);
        end
        else
        begin
            diag_next = diag_reg;
            row_next  = row_reg + IDX_W'(1);
            col_next  = col_reg - IDX_W'(1);
        end
    end

    assign rd_prod = CNT_W'(row_reg) * CNT_W'(cols) + CNT_W'(col_reg);
    assign rd_addr = rd_prod[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            diag_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + ADDR_W'(1);
            end

            if (cmd.walk_init)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                diag_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                diag_reg <= diag_next;
            end

            valid_reg <= cmd.walk_step;
            last_reg  <= cmd.walk_step && walk_last;
        end
    end

    // Store and registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[count_reg] <= element;
        end
        if (cmd.walk_step)
        begin
            rd_data_reg <= mem[rd_addr];
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
        end
    end

    assign result_valid = valid_reg;
    assign out_value    = rd_data_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_run  = last_reg;

    `ASSERT_SAME(a_walk_in_matrix, cmd.walk_step,
        (DIM_W'(row_reg) < rows) && (DIM_W'(col_reg) < cols),
        "walker left the matrix")
    `ASSERT_NEXT(a_read_gives_word, cmd.walk_step, result_valid,
        "read issued without a result word")
    `ASSERT_SAME(a_last_is_word, last_of_run, result_valid,
        "last mark without a result word")

endmodule

// ----- design/zzdr_ctrl.sv -----
`include "assert_macros.svh"

module zzdr_ctrl
    import zzdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  zzdr_status_t status,
    output zzdr_cmd_t    cmd,
    output logic         busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.full)
                    begin
                        cmd.count_clear = 1'b1;
                        cmd.walk_init   = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        cmd.count_inc = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_EMIT);

    `ASSERT_NEXT(a_full_starts_run, (state_reg == ST_IDLE) && start && status.full,
        state_reg == ST_EMIT, "completed matrix did not start a run")
    `ASSERT_NEXT(a_run_ends, (state_reg == ST_EMIT) && status.walk_last,
        state_reg == ST_IDLE, "run did not end on the final cell")
    `ASSERT_SAME(a_no_load_in_run, state_reg == ST_EMIT, !cmd.load && !cmd.count_inc,
        "store written during a run")

endmodule
